// ===== sv/i2cmra_pkg.sv =====
package i2cmra_pkg;

  // Bus phase of the bit-level sequencer
  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_START_A   = 4'd1,
    PH_START_B   = 4'd2,
    PH_RS_LOW    = 4'd3,
    PH_TX_LOW    = 4'd4,
    PH_TX_HIGH   = 4'd5,
    PH_ACK_LOW   = 4'd6,
    PH_ACK_HIGH  = 4'd7,
    PH_RX_LOW    = 4'd8,
    PH_RX_HIGH   = 4'd9,
    PH_MACK_LOW  = 4'd10,
    PH_MACK_HIGH = 4'd11,
    PH_STOP_A    = 4'd12,
    PH_STOP_B    = 4'd13,
    PH_STOP_C    = 4'd14
  } phase_t;

  // Which byte of the burst is on the bus
  typedef enum logic [1:0] {
    STG_ADDR_W = 2'd0,
    STG_REG    = 2'd1,
    STG_ADDR_R = 2'd2,
    STG_DATA   = 2'd3
  } stage_t;

  // Command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT    = 1'b1;

  localparam logic [6:0] ADDRESS_RESET = 7'd104;
  localparam logic [7:0] TIMEOUT_RESET = 8'd250;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // Sequencer state carried from one tick to the next
  typedef struct packed {
    phase_t     phase;
    stage_t     stage;
    logic [3:0] bit_count;
    logic [7:0] shift_byte;
    logic [7:0] bytes_left;
    logic [7:0] wait_count;
    logic [7:0] held_reg;
    logic       is_read;
    logic       aborted;
  } seq_state_t;

  // One result per tick
  typedef struct packed {
    logic       scl;
    logic       sda_drive_low;
    logic [7:0] rdata;
    logic       rdata_valid;
    logic       rdata_last;
    logic       wdata_take;
    logic       busy_res;
    logic       done_res;
    logic       error;
  } tick_res_t;

endpackage

// ===== sv/i2cmra_step.sv =====
module i2cmra_step (
  input  i2cmra_pkg::seq_state_t st,
  input  logic [6:0]             device_address,
  input  logic [7:0]             ack_timeout,
  input  logic [1:0]             cmd,
  input  logic [7:0]             reg_addr,
  input  logic [7:0]             length,
  input  logic [7:0]             wdata,
  input  logic                   sda_in,
  output i2cmra_pkg::seq_state_t st_nxt,
  output i2cmra_pkg::tick_res_t  res
);

  logic       scl_lvl;
  logic       sda_lvl;
  logic       write_next;
  logic [3:0] bit_inc;
  logic [7:0] left_dec;

  assign bit_inc  = st.bit_count + 4'd1;
  assign left_dec = (st.bytes_left != 8'd0) ? (st.bytes_left - 8'd1) : 8'd0;

  // Advance the sequencer by one bus tick
  always_comb begin
    st_nxt     = st;
    res        = '0;
    res.busy_res = 1'b1;
    scl_lvl    = 1'b1;
    sda_lvl    = 1'b1;
    write_next = 1'b0;
    case (st.phase)
      i2cmra_pkg::PH_IDLE: begin
        if (cmd == i2cmra_pkg::CMD_READ || cmd == i2cmra_pkg::CMD_WRITE) begin
          st_nxt.is_read    = (cmd == i2cmra_pkg::CMD_READ);
          st_nxt.held_reg   = reg_addr;
          st_nxt.bytes_left = length;
          st_nxt.stage      = i2cmra_pkg::STG_ADDR_W;
          st_nxt.aborted    = 1'b0;
          st_nxt.wait_count = 8'd0;
          st_nxt.bit_count  = 4'd0;
          st_nxt.phase      = i2cmra_pkg::PH_START_B;
        end else begin
          res.busy_res = 1'b0;
        end
      end
      i2cmra_pkg::PH_START_A: begin
        st_nxt.phase = i2cmra_pkg::PH_START_B;
      end
      i2cmra_pkg::PH_START_B: begin
        sda_lvl           = 1'b0;
        st_nxt.shift_byte = {device_address, st.stage == i2cmra_pkg::STG_ADDR_R};
        st_nxt.bit_count  = 4'd0;
        st_nxt.phase      = i2cmra_pkg::PH_TX_LOW;
      end
      i2cmra_pkg::PH_RS_LOW: begin
        scl_lvl      = 1'b0;
        st_nxt.phase = i2cmra_pkg::PH_START_A;
      end
      i2cmra_pkg::PH_TX_LOW: begin
        scl_lvl      = 1'b0;
        sda_lvl      = st.shift_byte[7];
        st_nxt.phase = i2cmra_pkg::PH_TX_HIGH;
      end
      i2cmra_pkg::PH_TX_HIGH: begin
        sda_lvl           = st.shift_byte[7];
        st_nxt.shift_byte = {st.shift_byte[6:0], 1'b0};
        if (bit_inc >= i2cmra_pkg::BITS_PER_BYTE) begin
          st_nxt.bit_count = 4'd0;
          st_nxt.phase     = i2cmra_pkg::PH_ACK_LOW;
        end else begin
          st_nxt.bit_count = bit_inc;
          st_nxt.phase     = i2cmra_pkg::PH_TX_LOW;
        end
      end
      i2cmra_pkg::PH_ACK_LOW: begin
        scl_lvl           = 1'b0;
        st_nxt.wait_count = 8'd0;
        st_nxt.phase      = i2cmra_pkg::PH_ACK_HIGH;
      end
      i2cmra_pkg::PH_ACK_HIGH: begin
        // Count high ticks until the target pulls SDA low or time runs out
        if (sda_in) begin
          if (st.wait_count >= ack_timeout) begin
            st_nxt.aborted = 1'b1;
            st_nxt.phase   = i2cmra_pkg::PH_STOP_A;
          end else begin
            st_nxt.wait_count = st.wait_count + 8'd1;
          end
        end else if (st.stage == i2cmra_pkg::STG_ADDR_W) begin
          st_nxt.shift_byte = st.held_reg;
          st_nxt.stage      = i2cmra_pkg::STG_REG;
          st_nxt.bit_count  = 4'd0;
          st_nxt.phase      = i2cmra_pkg::PH_TX_LOW;
        end else if (st.stage == i2cmra_pkg::STG_REG) begin
          if (st.is_read) begin
            st_nxt.stage = i2cmra_pkg::STG_ADDR_R;
            st_nxt.phase = i2cmra_pkg::PH_RS_LOW;
          end else begin
            write_next = 1'b1;
          end
        end else if (st.stage == i2cmra_pkg::STG_ADDR_R) begin
          st_nxt.shift_byte = 8'd0;
          st_nxt.bit_count  = 4'd0;
          st_nxt.phase      = (st.bytes_left == 8'd0) ? i2cmra_pkg::PH_STOP_A
                                                      : i2cmra_pkg::PH_RX_LOW;
        end else begin
          write_next = 1'b1;
        end
        // Load the next write byte or finish the burst
        if (write_next) begin
          if (st.bytes_left != 8'd0) begin
            st_nxt.shift_byte = wdata;
            res.wdata_take    = 1'b1;
            st_nxt.bytes_left = left_dec;
            st_nxt.stage      = i2cmra_pkg::STG_DATA;
            st_nxt.bit_count  = 4'd0;
            st_nxt.phase      = i2cmra_pkg::PH_TX_LOW;
          end else begin
            st_nxt.phase = i2cmra_pkg::PH_STOP_A;
          end
        end
      end
      i2cmra_pkg::PH_RX_LOW: begin
        scl_lvl      = 1'b0;
        st_nxt.phase = i2cmra_pkg::PH_RX_HIGH;
      end
      i2cmra_pkg::PH_RX_HIGH: begin
        st_nxt.shift_byte = {st.shift_byte[6:0], sda_in};
        if (bit_inc >= i2cmra_pkg::BITS_PER_BYTE) begin
          st_nxt.bit_count = 4'd0;
          st_nxt.phase     = i2cmra_pkg::PH_MACK_LOW;
        end else begin
          st_nxt.bit_count = bit_inc;
          st_nxt.phase     = i2cmra_pkg::PH_RX_LOW;
        end
      end
      i2cmra_pkg::PH_MACK_LOW: begin
        scl_lvl      = 1'b0;
        sda_lvl      = (st.bytes_left > 8'd1) ? 1'b0 : 1'b1;
        st_nxt.phase = i2cmra_pkg::PH_MACK_HIGH;
      end
      i2cmra_pkg::PH_MACK_HIGH: begin
        // Hand out the byte; NACK marks the last one
        sda_lvl           = (st.bytes_left > 8'd1) ? 1'b0 : 1'b1;
        res.rdata         = st.shift_byte;
        res.rdata_valid   = 1'b1;
        res.rdata_last    = (st.bytes_left <= 8'd1);
        st_nxt.bytes_left = left_dec;
        st_nxt.shift_byte = 8'd0;
        st_nxt.bit_count  = 4'd0;
        st_nxt.phase      = (left_dec == 8'd0) ? i2cmra_pkg::PH_STOP_A
                                               : i2cmra_pkg::PH_RX_LOW;
      end
      i2cmra_pkg::PH_STOP_A: begin
        scl_lvl      = 1'b0;
        sda_lvl      = 1'b0;
        st_nxt.phase = i2cmra_pkg::PH_STOP_B;
      end
      i2cmra_pkg::PH_STOP_B: begin
        sda_lvl      = 1'b0;
        st_nxt.phase = i2cmra_pkg::PH_STOP_C;
      end
      i2cmra_pkg::PH_STOP_C: begin
        res.done_res   = 1'b1;
        res.error      = st.aborted;
        st_nxt.aborted = 1'b0;
        st_nxt.phase   = i2cmra_pkg::PH_IDLE;
      end
      default: begin
        res.busy_res = 1'b0;
        st_nxt.phase = i2cmra_pkg::PH_IDLE;
      end
    endcase
    res.scl           = scl_lvl;
    res.sda_drive_low = ~sda_lvl;
  end

endmodule

// ===== sv/i2c_master_register_access.sv =====
// Channel   Direction  Handshake          Payload
// in_       request in in_valid/in_stall  cmd, reg_addr, length, wdata, sda_in
// out_      result out out_valid/out_stall scl, sda_drive_low, rdata, rdata_valid,
//                                          rdata_last, wdata_take, busy_res,
//                                          done_res, error
// cfg_      write in   cfg_wr_en          cfg_index, cfg_wdata
//
// Each request is one bus tick and yields exactly one result, passing through
// the request register and then the result register. One request per cycle
// is sustained while out_stall stays low; the sequencer step lies between them.
// Reset (synchronous, rst_n low) idles the sequencer and loads the register
// defaults. A stalled result holds the request register; in_stall rises only
// when both the request and result registers are full.
module i2c_master_register_access (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_cmd,
  input  logic [7:0]                         in_reg_addr,
  input  logic [7:0]                         in_length,
  input  logic [7:0]                         in_wdata,
  input  logic                               in_sda_in,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_scl,
  output logic                               out_sda_drive_low,
  output logic [7:0]                         out_rdata,
  output logic                               out_rdata_valid,
  output logic                               out_rdata_last,
  output logic                               out_wdata_take,
  output logic                               out_busy_res,
  output logic                               out_done_res,
  output logic                               out_error,
  input  logic                               cfg_wr_en,
  input  logic [i2cmra_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                         cfg_wdata
);

  logic                   req_valid_r;
  logic [1:0]             req_cmd_r;
  logic [7:0]             req_reg_addr_r;
  logic [7:0]             req_length_r;
  logic [7:0]             req_wdata_r;
  logic                   req_sda_r;
  logic [6:0]             dev_addr_r;
  logic [7:0]             ack_timeout_r;
  logic                   res_valid_r;
  i2cmra_pkg::tick_res_t  res_r;
  i2cmra_pkg::tick_res_t  res_nxt;
  i2cmra_pkg::seq_state_t seq_r;
  i2cmra_pkg::seq_state_t seq_nxt;
  logic                   res_free;
  logic                   step_go;

  assign res_free = ~res_valid_r | ~out_stall;
  assign step_go  = req_valid_r & res_free;
  assign in_stall = req_valid_r & ~res_free;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r    <= i2cmra_pkg::ADDRESS_RESET;
      ack_timeout_r <= i2cmra_pkg::TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_index == i2cmra_pkg::REG_DEVICE_ADDRESS) begin
        dev_addr_r <= cfg_wdata[6:0];
      end else if (cfg_index == i2cmra_pkg::REG_ACK_TIMEOUT) begin
        ack_timeout_r <= cfg_wdata;
      end
    end
  end

  // Capture a request whenever the request register is empty or moving on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (!req_valid_r || res_free) begin
      req_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_valid_r || res_free) begin
      req_cmd_r      <= in_cmd;
      req_reg_addr_r <= in_reg_addr;
      req_length_r   <= in_length;
      req_wdata_r    <= in_wdata;
      req_sda_r      <= in_sda_in;
    end
  end

  i2cmra_step u_step (
    .st             (seq_r),
    .device_address (dev_addr_r),
    .ack_timeout    (ack_timeout_r),
    .cmd            (req_cmd_r),
    .reg_addr       (req_reg_addr_r),
    .length         (req_length_r),
    .wdata          (req_wdata_r),
    .sda_in         (req_sda_r),
    .st_nxt         (seq_nxt),
    .res            (res_nxt)
  );

  // Advance sequencer state once per tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= '{phase: i2cmra_pkg::PH_IDLE, stage: i2cmra_pkg::STG_ADDR_W,
                 default: '0};
    end else if (step_go) begin
      seq_r <= seq_nxt;
    end
  end

  // Load the result register, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (step_go) begin
      res_valid_r <= 1'b1;
    end else if (!out_stall) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = res_valid_r;
  assign out_scl           = res_r.scl;
  assign out_sda_drive_low = res_r.sda_drive_low;
  assign out_rdata         = res_r.rdata;
  assign out_rdata_valid   = res_r.rdata_valid;
  assign out_rdata_last    = res_r.rdata_last;
  assign out_wdata_take    = res_r.wdata_take;
  assign out_busy_res      = res_r.busy_res;
  assign out_done_res      = res_r.done_res;
  assign out_error         = res_r.error;

`ifndef SYNTH
  a_error_only_at_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_done_res)
    else $error("error flagged without stop completion");

  a_last_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rdata_last |-> out_rdata_valid)
    else $error("last flag without a read byte");

  a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> out_busy_res && !out_sda_drive_low && out_scl)
    else $error("stop completion with bus not released");

  a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> res_valid_r && req_valid_r)
    else $error("request stalled with a free result register");
`endif

endmodule
